[rtl/hsfc_pkg.sv]
// Package for the half/single float converter.
// Holds the command codes and the two conversion functions; no dependencies.
package hsfc_pkg;

    typedef enum logic {
        CMD_S2H = 1'b0,
        CMD_H2S = 1'b1
    } cmd_t;

    localparam logic [15:0] HALF_QNAN = 16'h7E00;
    localparam logic [15:0] HALF_INF  = 16'h7C00;
    localparam logic [31:0] NORM_BIAS = 32'hC800_0FFF;

    // Single to half, round to nearest even
    function automatic logic [15:0] single_to_half(input logic [31:0] x);
        logic [15:0] sgn;
        logic [30:0] a;
        logic [15:0] h;
        logic [7:0]  e;
        logic [23:0] s;
        logic [7:0]  sh;
        logic [23:0] q;
        logic [23:0] r;
        logic [24:0] hf;
        logic [31:0] sum;
        begin
            sgn = {x[31], 15'd0};
            a   = x[30:0];
            e   = a[30:23];
            s   = {1'b0, a[22:0]};
            sum = '0;
            q   = '0;
            r   = '0;
            hf  = '0;
            sh  = '0;
            if (a >= 31'h4780_0000) begin
                h = (a > 31'h7F80_0000) ? HALF_QNAN : HALF_INF;
            end
            else if (a < 31'h3880_0000) begin
                if (e == 8'd0) begin
                    e = 8'd1;
                end
                else begin
                    s[23] = 1'b1;
                end
                sh = 8'd126 - e;
                if (sh > 8'd24) begin
                    h = 16'd0;
                end
                else begin
                    q  = s >> sh;
                    r  = s & ((24'd1 << sh) - 24'd1);
                    hf = 25'd1 << (sh - 8'd1);
                    if ({1'b0, r} > hf || ({1'b0, r} == hf && q[0])) begin
                        q = q + 24'd1;
                    end
                    h = q[15:0];
                end
            end
            else begin
                sum = {1'b0, a} + NORM_BIAS + {31'd0, a[13]};
                h   = sum[28:13];
            end
            single_to_half = h | sgn;
        end
    endfunction

    // Half to single, exact
    function automatic logic [31:0] half_to_single(input logic [15:0] x);
        logic [4:0]  e;
        logic [9:0]  m;
        logic [31:0] f;
        logic [3:0]  p;
        logic [9:0]  ms;
        begin
            e  = x[14:10];
            m  = x[9:0];
            p  = 4'd0;
            ms = '0;
            if (e == 5'h1F) begin
                f = {1'b0, 8'hFF, m, 13'd0};
            end
            else if (e != 5'd0) begin
                f = {1'b0, {3'd0, e} + 8'd112, m, 13'd0};
            end
            else if (m == 10'd0) begin
                f = 32'd0;
            end
            else begin
                // Leading-one position of the subnormal mantissa
                for (int i = 0; i < 10; i++) begin
                    if (m[i]) begin
                        p = 4'(i);
                    end
                end
                ms = m << (4'd10 - p);
                f  = {1'b0, {4'd0, p} + 8'd103, ms, 13'd0};
            end
            half_to_single = f | {x[15], 31'd0};
        end
    endfunction

endpackage

[rtl/hsfc_convert.sv]
// Combinational conversion datapath for the half/single float converter.
// Depends on hsfc_pkg.
module hsfc_convert
    import hsfc_pkg::*;
(
    input  logic [0:0]  cmd,
    input  logic [31:0] operand_bits,
    output logic [31:0] result_bits
);

    // Select the direction
    always_comb
    begin
        case (cmd_t'(cmd))
            CMD_S2H: result_bits = {16'd0, single_to_half(operand_bits)};
            CMD_H2S: result_bits = half_to_single(operand_bits[15:0]);
            default: result_bits = '0;
        endcase
    end

endmodule

[rtl/half_single_float_converter_core.sv]
// Top level of the IEEE 754 binary32 <-> binary16 converter.
// Depends on hsfc_pkg and hsfc_convert.
//
// Usage:
//   Input channel: in_valid/in_stall with cmd (0 single to half, 1 half to
//   single) and operand_bits. Output channel: out_valid/out_stall with
//   result_bits; a half result is zero-extended.
//   Each transaction is registered at the input, converted by one level of
//   combinational logic, and held in the result register. out_valid rises
//   once the transaction moves from the input register into the result
//   register. Throughput is one transaction per cycle while the receiver
//   does not stall, set by the two-register pipeline with no loops.
//   When the receiver stalls, the result register holds its transaction; the
//   input register keeps taking one more, then in_stall rises until the
//   result register drains.
//   Reset clears both valid flags; no transaction is in flight afterward.
module half_single_float_converter_core
    import hsfc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [0:0]  cmd,
    input  logic [31:0] operand_bits,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] result_bits
);

    logic        in_vld_reg;
    logic [0:0]  cmd_reg;
    logic [31:0] op_reg;
    logic        out_vld_reg;
    logic [31:0] res_reg;
    logic [31:0] conv;
    logic        adv;

    hsfc_convert u_convert (
        .cmd          (cmd_reg),
        .operand_bits (op_reg),
        .result_bits  (conv)
    );

    // Advance the input stage into the result register when it is free
    assign adv      = !out_vld_reg || !out_stall;
    assign in_stall = in_vld_reg && !adv;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_vld_reg <= 1'b0;
        end
        else if (!in_stall) begin
            in_vld_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall) begin
            cmd_reg <= cmd;
            op_reg  <= operand_bits;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_vld_reg <= 1'b0;
        end
        else if (adv) begin
            out_vld_reg <= in_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && in_vld_reg) begin
            res_reg <= conv;
        end
    end

    assign out_valid   = out_vld_reg;
    assign result_bits = res_reg;

`ifndef SYNTHESIS
    // Stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(result_bits))
        else $error("result changed under stall");
    // Input stalls only with both stages full
    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> in_vld_reg && out_vld_reg && out_stall)
        else $error("spurious input stall");
    // Accepted transaction reaches the input stage
    a_load: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_vld_reg)
        else $error("accepted transaction lost");
    // Half results are zero-extended
    a_zext: assert property (@(posedge clk) disable iff (!rst_n)
        in_vld_reg && adv && cmd_reg == CMD_S2H |=> result_bits[31:16] == 16'd0)
        else $error("half result not zero-extended");
`endif

endmodule
